### src/aamd_pkg.sv
package aamd_pkg;

    // Pixel and channel geometry
    localparam int CH_W  = 8;
    localparam int PIX_W = 4 * CH_W;
    localparam int NUM_CH = 4;

    // Configuration port
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] SOURCE_WIDTH_RESET  = 11'd16;
    localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RESET = 11'd16;

    // Default buffer limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Block arithmetic: sums of four 8-bit channels, count of visible pixels
    localparam int SUM_W = CH_W + 2;
    localparam int CNT_W = 3;
    // floor(s / 3) == (s * 683) >> 11 for every s below 1024
    localparam int RECIP3_W     = 10;
    localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;
    localparam int RECIP3_SHIFT = 11;
    localparam int PROD_W       = SUM_W + RECIP3_W;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ram_we;     // write the incoming pixel to the row buffer
        logic ram_re;     // read the row buffer at the current column
        logic cur_load;   // capture the incoming pixel
        logic left_load;  // capture the incoming pixel as the lower left one
        logic tl_load;    // capture row buffer data as the upper left pixel
        logic sum_load;   // register sums, visible count and translucency
        logic out_load;   // load the divided result into the output register
        logic last;       // last flag that goes with the loaded result
    } aamd_cmd_t;

endpackage

### src/aamd_ram.sv
module aamd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/aamd_ctrl.sv
module aamd_ctrl
    import aamd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_start,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [AW-1:0]        ram_addr,
    output aamd_cmd_t            cmd
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV
    } state_t;

    state_t         state_reg, state_next;
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic           tl_load_reg, tl_load_next;
    logic           last_reg, last_next;
    logic           out_valid_reg, out_valid_next;

    logic [CW-1:0]  w_eff;
    logic [RW-1:0]  h_eff;
    logic [CW-1:0]  c0, c1;
    logic [RW-1:0]  r0, r1;
    logic           accept;
    logic           out_load;

    // Effective image size: clamped to the buffer limits and made even
    always_comb
    begin
        if (int'(width_reg) < 2)
        begin
            w_eff = CW'(2);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(width_reg);
        end
        w_eff = w_eff & ~CW'(1);
    end

    always_comb
    begin
        if (int'(height_reg) < 2)
        begin
            h_eff = RW'(2);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = RW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = RW'(height_reg);
        end
        h_eff = h_eff & ~RW'(1);
    end

    // Position of the incoming pixel and of the one after it
    always_comb
    begin
        c0 = in_start ? '0 : col_reg;
        r0 = in_start ? '0 : row_reg;
        if (c0 >= w_eff)
        begin
            c0 = '0;
            r0 = r0 + RW'(1);
        end
        if (r0 >= h_eff)
        begin
            r0 = '0;
        end
        c1 = c0 + CW'(1);
        r1 = r0;
        if (c1 >= w_eff)
        begin
            c1 = '0;
            r1 = r0 + RW'(1);
            if (r1 >= h_eff)
            begin
                r1 = '0;
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == ST_DIV) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign ram_addr  = c0[AW-1:0];

    // Commands to the datapath
    always_comb
    begin
        cmd.ram_we    = accept && !r0[0];
        cmd.ram_re    = accept && r0[0];
        cmd.cur_load  = accept;
        cmd.left_load = accept && r0[0] && !c0[0];
        cmd.tl_load   = tl_load_reg;
        cmd.sum_load  = (state_reg == ST_SUM);
        cmd.out_load  = out_load;
        cmd.last      = last_reg;
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        last_next      = last_reg;
        tl_load_next   = accept && r0[0] && !c0[0];
        out_valid_next = out_valid_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  width_next  = cfg_data;
                REG_SOURCE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_next  = c1;
                    row_next  = r1;
                    last_next = (r0 == h_eff - RW'(1)) && (c0 == w_eff - CW'(1));
                    if (r0[0] && c0[0])
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= SOURCE_WIDTH_RESET;
            height_reg    <= SOURCE_HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            tl_load_reg   <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            tl_load_reg   <= tl_load_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/aamd_dp.sv
module aamd_dp
    import aamd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic             clk,
    input  aamd_cmd_t        cmd,
    input  logic [AW-1:0]    ram_addr,
    input  logic [PIX_W-1:0] pix_in,
    output logic [PIX_W-1:0] pix_out,
    output logic             last_out
);

    logic [PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0] cur_reg;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] tl_reg;
    logic [SUM_W-1:0] sum_reg [NUM_CH];
    logic [SUM_W-1:0] sum_next [NUM_CH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             trans_reg, trans_next;
    logic [PIX_W-1:0] out_data_reg;
    logic             out_last_reg;
    logic [PIX_W-1:0] px [4];
    logic [CH_W-1:0]  quot [NUM_CH];
    logic [PROD_W-1:0] prod [NUM_CH];

    // Row buffer holding the even source row
    aamd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_buf (
        .clk   (clk),
        .en    (cmd.ram_we || cmd.ram_re),
        .we    (cmd.ram_we),
        .addr  (ram_addr),
        .wdata (pix_in),
        .rdata (ram_rdata)
    );

    // The four pixels of the block; the upper right one comes straight from the buffer
    always_comb
    begin
        px[0] = tl_reg;
        px[1] = ram_rdata;
        px[2] = left_reg;
        px[3] = cur_reg;
    end

    // Channel sums over visible pixels, their count and translucency
    always_comb
    begin
        cnt_next   = '0;
        trans_next = 1'b0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum_next[c] = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (px[i][3*CH_W +: CH_W] != '0)
            begin
                cnt_next = cnt_next + CNT_W'(1);
                for (int c = 0; c < NUM_CH; c++)
                begin
                    sum_next[c] = sum_next[c] + SUM_W'(px[i][c*CH_W +: CH_W]);
                end
                if (px[i][3*CH_W +: CH_W] != '1)
                begin
                    trans_next = 1'b1;
                end
            end
        end
    end

    // Truncating division by the visible count; three goes through a reciprocal
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod[c] = PROD_W'(sum_reg[c]) * PROD_W'(RECIP3);
            case (cnt_reg)
                3'd1:    quot[c] = sum_reg[c][CH_W-1:0];
                3'd2:    quot[c] = sum_reg[c][CH_W:1];
                3'd3:    quot[c] = prod[c][RECIP3_SHIFT +: CH_W];
                3'd4:    quot[c] = sum_reg[c][CH_W+1:2];
                default: quot[c] = '0;
            endcase
        end
        // Blocks of only fully opaque and transparent pixels keep a hard edge
        if (!trans_reg && quot[3] != '0)
        begin
            quot[3] = '1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cur_load)
        begin
            cur_reg <= pix_in;
        end
        if (cmd.left_load)
        begin
            left_reg <= pix_in;
        end
        if (cmd.tl_load)
        begin
            tl_reg <= ram_rdata;
        end
        if (cmd.sum_load)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
            cnt_reg   <= cnt_next;
            trans_reg <= trans_next;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {quot[3], quot[2], quot[1], quot[0]};
            out_last_reg <= cmd.last;
        end
    end

    assign pix_out  = out_data_reg;
    assign last_out = out_last_reg;

endmodule

### src/alpha_aware_mipmap_downsample.sv
// Alpha-aware 2x2 mipmap downsampler.
//
// The slave stream takes source RGBA8 pixels in raster order: s_axis_tdata
// holds red, green, blue and alpha from the lowest byte up, and s_axis_tuser
// marks the first pixel of an image. The master stream returns the next
// mipmap level in raster order, one pixel per 2x2 block, with m_axis_tlast
// on the final pixel of the output image. Image size is set through the
// configuration port (index 0 is the source width, index 1 the height) while
// the block is idle; both reset to 16.
//
// Pixels of even rows are written to the row buffer at one per cycle while
// s_axis_tready is high. On odd rows the left pixel of a pair is taken and
// held; the right pixel starts a three-step sequence (row buffer read, sum,
// divide), and s_axis_tready stays low until the divided result is loaded
// into the output register that drives m_axis_tvalid. The single-port row
// buffer and the shared sum and divide sequence set the odd-row input rate.
//
// Reset clears the position counters and the output valid flag; the row
// buffer is not cleared. While the receiver stalls, one finished result
// waits in the output register and input is still taken until the next
// result is ready to be loaded.
module alpha_aware_mipmap_downsample
    import aamd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
    input  logic                 s_axis_tuser,   // image_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic                 m_axis_tlast    // last_out
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    aamd_cmd_t     cmd;
    logic [AW-1:0] ram_addr;

    aamd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_start  (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ram_addr  (ram_addr),
        .cmd       (cmd)
    );

    aamd_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .ram_addr (ram_addr),
        .pix_in   (s_axis_tdata),
        .pix_out  (m_axis_tdata),
        .last_out (m_axis_tlast)
    );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import aamd_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int MAX_H         = DEF_MAX_HEIGHT;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_AT       = 40;
    localparam int HOLD_LEN      = 300;

    // Directed 2x2 blocks, four pixels each: top left, top right, bottom left,
    // bottom right. Pixels are written as alpha, blue, green, red.
    localparam logic [32*PIX_W-1:0] DIR_QUADS = {
        // all transparent, colors must be dropped
        32'h00FF_FFFF, 32'h00FF_FFFF, 32'h0012_3456, 32'h00FF_FFFF,
        // all opaque white
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        // all opaque black
        32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000,
        // a single translucent pixel is visible
        32'h00FF_FFFF, 32'h801E_140A, 32'h0000_0000, 32'h00FF_FFFF,
        // three opaque pixels, divide by three
        32'hFF00_00FF, 32'hFF00_00FE, 32'hFF00_0001, 32'h00FF_FFFF,
        // two barely translucent pixels keep their averaged alpha
        32'h01FF_0000, 32'h00FF_FFFF, 32'hFE00_FF00, 32'h00FF_FFFF,
        // opaque and transparent only, alpha is forced opaque
        32'hFF10_2030, 32'h00FF_FFFF, 32'hFF30_2010, 32'h00AB_CDEF,
        // four faint pixels, truncating division of large sums
        32'h01FF_FFFF, 32'h01FF_FFFF, 32'h01FF_FFFF, 32'h01FE_FEFE
    };

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            image_start;
    } src_px_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            last;
    } mip_px_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;

    // Source pixels waiting to be offered, and downsampled pixels predicted
    src_px_t pixel_q [$];
    mip_px_t mip_q [$];

    int px_pushed  = 0;
    int px_taken   = 0;
    int mip_seen   = 0;
    int err_cnt    = 0;
    int idle_cycles = 0;
    bit steady     = 1'b0;
    bit hold_done  = 1'b0;

    // Shadow of the block: configuration, line memory and raster position
    logic [CFG_W-1:0] shadow_width  = SOURCE_WIDTH_RESET;
    logic [CFG_W-1:0] shadow_height = SOURCE_HEIGHT_RESET;
    logic [PIX_W-1:0] line_mem [MAX_W];
    logic [PIX_W-1:0] left_px = '0;
    int col_pos = 0;
    int row_pos = 0;

    // Effective width the stimulus generator assumes is in use
    int gen_width = 16;

    alpha_aware_mipmap_downsample #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int even_clamp(input int v, input int maxv);
        if (v < 2)
            v = 2;
        if (v > maxv)
            v = maxv;
        return v & ~1;
    endfunction

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else if (r < 98)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    // Average the visible pixels of one 2x2 block.
    function automatic mip_px_t box_filter(input logic [PIX_W-1:0] tl, input logic [PIX_W-1:0] tr,
                                           input logic [PIX_W-1:0] bl, input logic [PIX_W-1:0] br);
        logic [PIX_W-1:0] quad [4];
        int sum [4];
        int visible;
        bit translucent;
        int a;
        mip_px_t res;
        quad[0] = tl;
        quad[1] = tr;
        quad[2] = bl;
        quad[3] = br;
        visible = 0;
        translucent = 1'b0;
        for (int c = 0; c < 4; c++)
            sum[c] = 0;
        for (int i = 0; i < 4; i++)
        begin
            a = quad[i][31:24];
            if (a > 0 && a < 255)
                translucent = 1'b1;
            if (a > 0)
            begin
                for (int c = 0; c < 4; c++)
                    sum[c] += quad[i][8*c +: 8];
                visible++;
            end
        end
        for (int c = 0; c < 4; c++)
            sum[c] = (visible != 0) ? sum[c] / visible : 0;
        // Blocks with only opaque and transparent pixels stay fully opaque.
        if (!translucent && sum[3] > 0)
            sum[3] = 255;
        res.red   = CH_W'(sum[0]);
        res.green = CH_W'(sum[1]);
        res.blue  = CH_W'(sum[2]);
        res.alpha = CH_W'(sum[3]);
        res.last  = 1'b0;
        return res;
    endfunction

    // Advance the shadow raster position by one accepted source pixel and
    // queue the downsampled pixel when it closes a 2x2 block.
    task automatic predict_mip(input src_px_t px);
        int w;
        int h;
        int col;
        int row;
        logic [PIX_W-1:0] cur;
        mip_px_t res;
        w = even_clamp(shadow_width, MAX_W);
        h = even_clamp(shadow_height, MAX_H);
        cur = {px.alpha, px.blue, px.green, px.red};
        if (px.image_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        // A shrunken size moves the position back into range.
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        col = col_pos;
        row = row_pos;
        if (row % 2 == 0)
            line_mem[col] = cur;
        else if (col % 2 == 0)
            left_px = cur;
        else
        begin
            res = box_filter(line_mem[col-1], line_mem[col], left_px, cur);
            res.last = (row == h - 1) && (col == w - 1);
            mip_q.push_back(res);
        end
        col_pos = col + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    task automatic check_mip();
        mip_px_t want;
        if (mip_q.size() == 0)
        begin
            $error("unexpected output pixel %h last %b", m_axis_tdata, m_axis_tlast);
            err_cnt++;
        end
        else
        begin
            want = mip_q.pop_front();
            if (m_axis_tdata[7:0] !== want.red)
            begin
                $error("red_out expected %0d actual %0d", want.red, m_axis_tdata[7:0]);
                err_cnt++;
            end
            if (m_axis_tdata[15:8] !== want.green)
            begin
                $error("green_out expected %0d actual %0d", want.green, m_axis_tdata[15:8]);
                err_cnt++;
            end
            if (m_axis_tdata[23:16] !== want.blue)
            begin
                $error("blue_out expected %0d actual %0d", want.blue, m_axis_tdata[23:16]);
                err_cnt++;
            end
            if (m_axis_tdata[31:24] !== want.alpha)
            begin
                $error("alpha_out expected %0d actual %0d", want.alpha, m_axis_tdata[31:24]);
                err_cnt++;
            end
            if (m_axis_tlast !== want.last)
            begin
                $error("last_out expected %0d actual %0d", want.last, m_axis_tlast);
                err_cnt++;
            end
        end
        mip_seen++;
    endtask

    // Source side: offer queued pixels, with random gaps between requests.
    src_px_t on_bus;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_mip(on_bus);
                px_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_q.size() != 0)
                begin
                    on_bus = pixel_q.pop_front();
                    s_axis_tdata  <= {on_bus.alpha, on_bus.blue, on_bus.green, on_bus.red};
                    s_axis_tuser  <= on_bus.image_start;
                    s_axis_tvalid <= 1'b1;
                    gap_left = steady ? 0 : pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side: check each accepted request and stall at random. One long
    // hold-off lets the block fill up and back-pressure its input.
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_mip();
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && mip_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                stall_left = HOLD_LEN - 1;
                m_axis_tready <= 1'b0;
            end
            else if (steady || $urandom_range(3) != 0)
                m_axis_tready <= 1'b1;
            else
            begin
                stall_left = pick_gap();
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Watchdog on cycles without any accepted request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $error("stalled with %0d output pixels outstanding", mip_q.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic push_px(input logic [PIX_W-1:0] rgba, input logic start);
        src_px_t px;
        px.red         = rgba[7:0];
        px.green       = rgba[15:8];
        px.blue        = rgba[23:16];
        px.alpha       = rgba[31:24];
        px.image_start = start;
        pixel_q.push_back(px);
        px_pushed++;
    endtask

    function automatic logic [CH_W-1:0] rand_chan();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return CH_W'($urandom_range(255));
    endfunction

    // Alpha mix: 0 = mixed, 1 = only transparent or opaque, 2 = mostly translucent.
    function automatic logic [CH_W-1:0] rand_alpha(input int mode);
        int r;
        r = $urandom_range(99);
        if (mode == 1)
            return (r < 50) ? 8'd0 : 8'd255;
        else if (mode == 2)
            return (r < 10) ? 8'd0 : CH_W'($urandom_range(254, 1));
        else if (r < 30)
            return 8'd0;
        else if (r < 65)
            return 8'd255;
        else
            return CH_W'($urandom_range(255));
    endfunction

    // One raster image, or the first count pixels of one.
    task automatic push_image(input int count, input logic mark);
        int mode;
        mode = $urandom_range(2);
        for (int k = 0; k < count; k++)
            push_px({rand_alpha(mode), rand_chan(), rand_chan(), rand_chan()}, mark && k == 0);
    endtask

    task automatic push_noise(input int count);
        for (int k = 0; k < count; k++)
            push_px($urandom, $urandom_range(99) < 15);
    endtask

    // Wait until every pixel was taken and every result has come back, then
    // let the pipeline settle on pixels that produce no result.
    task automatic wait_drained();
        while (px_taken != px_pushed || mip_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SOURCE_WIDTH)
            shadow_width = val;
        else
            shadow_height = val;
    endtask

    // Reconfigure while idle, then stream images. A wider image restarts at
    // the first pixel so that no row buffer entry is read before written.
    task automatic run_phase(input int wr, input int hr, input int n_img, input int n_noise,
                             input bit cut_short, input bit calm);
        int w_new;
        int h_new;
        logic mark;
        wait_drained();
        w_new = even_clamp(wr, MAX_W);
        h_new = even_clamp(hr, MAX_H);
        mark = (w_new > gen_width) ? 1'b1 : ($urandom_range(1) == 1);
        write_reg(REG_SOURCE_WIDTH, CFG_W'(wr));
        write_reg(REG_SOURCE_HEIGHT, CFG_W'(hr));
        gen_width = w_new;
        steady = calm;
        for (int i = 0; i < n_img; i++)
            push_image(w_new * h_new, (i == 0) ? mark : ($urandom_range(4) != 0));
        push_noise(n_noise);
        if (cut_short)
            push_image($urandom_range(w_new * h_new - 1, 1), $urandom_range(1) == 1);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed blocks at the reset size: first two rows of a 16 wide image.
        for (int k = 0; k < 8; k++)
        begin
            push_px(DIR_QUADS[(31 - 4*k) * PIX_W +: PIX_W], k == 0);
            push_px(DIR_QUADS[(31 - 4*k - 1) * PIX_W +: PIX_W], 1'b0);
        end
        for (int k = 0; k < 8; k++)
        begin
            push_px(DIR_QUADS[(31 - 4*k - 2) * PIX_W +: PIX_W], 1'b0);
            push_px(DIR_QUADS[(31 - 4*k - 3) * PIX_W +: PIX_W], 1'b0);
        end

        // Random images over a range of sizes, clamped sizes included.
        run_phase(8, 6, 5, 20, 1'b0, 1'b0);
        run_phase(4, 4, 6, 0, 1'b1, 1'b1);
        run_phase(0, 1, 10, 12, 1'b0, 1'b0);
        run_phase(3, 5, 10, 0, 1'b1, 1'b0);
        run_phase(1, 2047, 0, 40, 1'b0, 1'b1);
        run_phase(6, 8, 2, 16, 1'b1, 1'b0);
        run_phase(14, 4, 2, 0, 1'b0, 1'b0);
        run_phase(16, 16, 1, 0, 1'b0, 1'b0);
        run_phase(10, 12, 1, 0, 1'b0, 1'b0);
        run_phase(12, 2, 5, 8, 1'b0, 1'b1);
        run_phase(5, 3, 10, 20, 1'b1, 1'b0);

        wait_drained();
        if (err_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
